// ===== src/bounded_descriptor_queue_drop_oldest_macros.svh =====
// Assertion macros for the descriptor queue.
// Both macros use clk_i and rst_ni of the module that expands them.
`ifndef BOUNDED_DESCRIPTOR_QUEUE_DROP_OLDEST_MACROS_SVH
`define BOUNDED_DESCRIPTOR_QUEUE_DROP_OLDEST_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BDQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BDQ_ASSERT(lbl, prop, msg)
`define BDQ_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== src/bdq_pkg.sv =====
package bdq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned HANDLE_BITS = 8;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned STAT_W      = 32;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;

  typedef enum logic [1:0] {
    REQ_SEND  = 2'd0,
    REQ_RECV  = 2'd1,
    REQ_CLOSE = 2'd2,
    REQ_STAT  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_CLOSED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SEL_SENT     = 3'd0,
    SEL_RECEIVED = 3'd1,
    SEL_FULL     = 3'd2,
    SEL_DROPPED  = 3'd3,
    SEL_TIMEOUT  = 3'd4,
    SEL_PEAK     = 3'd5,
    SEL_DEPTH    = 3'd6,
    SEL_CAPACITY = 3'd7
  } stat_e;

  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0,
    REG_POLICY   = 1'b1
  } reg_e;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic             drop_oldest;
  } cfg_t;

  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    logic [CAP_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CAP_W'(1);
    end else if ({1'b0, v} > (CAP_W+1)'(QUEUE_DEPTH)) begin
      r = CAP_W'(QUEUE_DEPTH);
    end
    return r;
  endfunction

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    return (&v) ? v : v + STAT_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
    return (i == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : i + PTR_W'(1);
  endfunction

endpackage

// ===== src/bdq_ram.sv =====
module bdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bdq_cfg.sv =====
module bdq_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdq_pkg::ADDR_W-1:0]  paddr,
  input  logic [bdq_pkg::DATA_W-1:0]  pwdata,
  output logic [bdq_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bdq_pkg::cfg_t               cfg_o
);

  logic [bdq_pkg::CAP_W-1:0] cap_q, cap_d;
  logic                      pol_q, pol_d;
  logic                      wr;
  bdq_pkg::reg_e             reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = bdq_pkg::reg_e'(paddr[2]);

  always_comb begin
    cap_d  = cap_q;
    pol_d  = pol_q;
    prdata = '0;
    case (reg_idx)
      bdq_pkg::REG_CAPACITY: begin
        prdata = bdq_pkg::DATA_W'(cap_q);
        if (wr) begin
          cap_d = bdq_pkg::clamp_cap(pwdata[bdq_pkg::CAP_W-1:0]);
        end
      end
      bdq_pkg::REG_POLICY: begin
        prdata = bdq_pkg::DATA_W'(pol_q);
        if (wr) begin
          pol_d = pwdata[0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bdq_pkg::CAP_W'(bdq_pkg::QUEUE_DEPTH);
      pol_q <= 1'b0;
    end else begin
      cap_q <= cap_d;
      pol_q <= pol_d;
    end
  end

  assign cfg_o.capacity    = cap_q;
  assign cfg_o.drop_oldest = pol_q;

endmodule

// ===== src/bdq_ctrl.sv =====
`include "bounded_descriptor_queue_drop_oldest_macros.svh"

module bdq_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bdq_pkg::cfg_t                    cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       req_type_i,
  input  logic [bdq_pkg::HANDLE_BITS-1:0]  buffer_handle_i,
  input  logic [2:0]                       stat_select_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [bdq_pkg::HANDLE_BITS-1:0]  out_handle_o,
  output logic                             out_handle_valid_o,
  output logic                             dropped_valid_o,
  output logic [bdq_pkg::HANDLE_BITS-1:0]  dropped_handle_o,
  output logic [bdq_pkg::CNT_W-1:0]        depth_o,
  output logic [bdq_pkg::STAT_W-1:0]       stat_value_o,
  output logic                             ram_we_o,
  output logic [bdq_pkg::PTR_W-1:0]        ram_waddr_o,
  output logic [bdq_pkg::HANDLE_BITS-1:0]  ram_wdata_o,
  output logic                             ram_re_o,
  output logic [bdq_pkg::PTR_W-1:0]        ram_raddr_o,
  input  logic [bdq_pkg::HANDLE_BITS-1:0]  ram_rdata_i
);

  localparam int unsigned CNT_W  = bdq_pkg::CNT_W;
  localparam int unsigned PTR_W  = bdq_pkg::PTR_W;
  localparam int unsigned STAT_W = bdq_pkg::STAT_W;

  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              closed_q, closed_d;
  logic [STAT_W-1:0] sent_q, sent_d, recv_q, recv_d, full_q, full_d;
  logic [STAT_W-1:0] drop_q, drop_d, tmo_q, tmo_d;
  logic [CNT_W-1:0]  peak_q, peak_d;

  logic              ov_q;
  bdq_pkg::status_e  status_q, status_d;
  logic              ohv_q, ohv_d, dv_q, dv_d;
  logic [STAT_W-1:0] sv_q, sv_d;

  logic              in_acc;
  logic [CNT_W-1:0]  cap;
  logic              is_full, still_full, do_drop;
  logic [PTR_W-1:0]  head1;
  logic [CNT_W-1:0]  cnt1;
  logic [CNT_W:0]    tail_sum;
  logic [PTR_W-1:0]  tail;
  bdq_pkg::req_e     req;
  bdq_pkg::stat_e    sel;

  assign in_stall_o = ov_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign req        = bdq_pkg::req_e'(req_type_i);
  assign sel        = bdq_pkg::stat_e'(stat_select_i);
  assign cap        = CNT_W'(cfg_i.capacity);

  assign is_full    = cnt_q >= cap;
  assign do_drop    = is_full && cfg_i.drop_oldest && !closed_q && (cnt_q != '0);
  assign head1      = do_drop ? bdq_pkg::ring_next(head_q) : head_q;
  assign cnt1       = do_drop ? cnt_q - CNT_W'(1) : cnt_q;
  assign still_full = cnt1 >= cap;
  assign tail_sum   = {1'b0, CNT_W'(head1)} + {1'b0, cnt1};
  assign tail       = (tail_sum >= (CNT_W+1)'(bdq_pkg::QUEUE_DEPTH))
                      ? PTR_W'(tail_sum - (CNT_W+1)'(bdq_pkg::QUEUE_DEPTH))
                      : PTR_W'(tail_sum);

  // head slot is read on every transaction; data lands with the result
  assign ram_re_o    = in_acc;
  assign ram_raddr_o = head_q;
  assign ram_waddr_o = tail;
  assign ram_wdata_o = buffer_handle_i;

  always_comb begin
    head_d   = head_q;
    cnt_d    = cnt_q;
    closed_d = closed_q;
    sent_d   = sent_q;
    recv_d   = recv_q;
    full_d   = full_q;
    drop_d   = drop_q;
    tmo_d    = tmo_q;
    peak_d   = peak_q;
    status_d = bdq_pkg::ST_OK;
    ohv_d    = 1'b0;
    dv_d     = 1'b0;
    sv_d     = '0;
    ram_we_o = 1'b0;
    case (req)
      bdq_pkg::REQ_SEND: begin
        if (is_full) begin
          full_d = bdq_pkg::sat_inc(full_q);
        end
        if (do_drop) begin
          dv_d   = 1'b1;
          drop_d = bdq_pkg::sat_inc(drop_q);
          head_d = head1;
          cnt_d  = cnt1;
        end
        if (closed_q) begin
          status_d = bdq_pkg::ST_CLOSED;
        end else if (still_full) begin
          status_d = bdq_pkg::ST_FULL;
        end else begin
          ram_we_o = in_acc;
          cnt_d    = cnt1 + CNT_W'(1);
          sent_d   = bdq_pkg::sat_inc(sent_q);
          if (cnt1 + CNT_W'(1) > peak_q) begin
            peak_d = cnt1 + CNT_W'(1);
          end
        end
      end
      bdq_pkg::REQ_RECV: begin
        if (cnt_q != '0) begin
          ohv_d  = 1'b1;
          head_d = bdq_pkg::ring_next(head_q);
          cnt_d  = cnt_q - CNT_W'(1);
          recv_d = bdq_pkg::sat_inc(recv_q);
        end else if (closed_q) begin
          status_d = bdq_pkg::ST_CLOSED;
        end else begin
          status_d = bdq_pkg::ST_EMPTY;
          tmo_d    = bdq_pkg::sat_inc(tmo_q);
        end
      end
      bdq_pkg::REQ_CLOSE: begin
        closed_d = 1'b1;
      end
      default: begin
        case (sel)
          bdq_pkg::SEL_SENT:     sv_d = sent_q;
          bdq_pkg::SEL_RECEIVED: sv_d = recv_q;
          bdq_pkg::SEL_FULL:     sv_d = full_q;
          bdq_pkg::SEL_DROPPED:  sv_d = drop_q;
          bdq_pkg::SEL_TIMEOUT:  sv_d = tmo_q;
          bdq_pkg::SEL_PEAK:     sv_d = STAT_W'(peak_q);
          bdq_pkg::SEL_DEPTH:    sv_d = STAT_W'(cnt_q);
          default:               sv_d = STAT_W'(cfg_i.capacity);
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      cnt_q    <= '0;
      closed_q <= 1'b0;
      sent_q   <= '0;
      recv_q   <= '0;
      full_q   <= '0;
      drop_q   <= '0;
      tmo_q    <= '0;
      peak_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (in_acc) begin
        head_q   <= head_d;
        cnt_q    <= cnt_d;
        closed_q <= closed_d;
        sent_q   <= sent_d;
        recv_q   <= recv_d;
        full_q   <= full_d;
        drop_q   <= drop_d;
        tmo_q    <= tmo_d;
        peak_q   <= peak_d;
        ov_q     <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= status_d;
      ohv_q    <= ohv_d;
      dv_q     <= dv_d;
      sv_q     <= sv_d;
    end
  end

  assign out_valid_o        = ov_q;
  assign status_o           = status_q;
  assign out_handle_valid_o = ohv_q;
  assign dropped_valid_o    = dv_q;
  assign out_handle_o       = ohv_q ? ram_rdata_i : '0;
  assign dropped_handle_o   = dv_q ? ram_rdata_i : '0;
  assign depth_o            = cnt_q;
  assign stat_value_o       = sv_q;

  `BDQ_ASSERT_NEVER(a_cnt_bound, cnt_q > CNT_W'(bdq_pkg::QUEUE_DEPTH), "entry count over depth")
  `BDQ_ASSERT_NEVER(a_peak_ge_cnt, peak_q < cnt_q, "peak depth below current depth")
  `BDQ_ASSERT_NEVER(a_one_handle, ov_q && ohv_q && dv_q, "dequeue and drop in one result")
  `BDQ_ASSERT(a_recv_pops, in_acc && req == bdq_pkg::REQ_RECV && cnt_q != '0 |=> ov_q && ohv_q && cnt_q == $past(cnt_q) - CNT_W'(1), "receive did not pop")

endmodule

// ===== src/bounded_descriptor_queue_drop_oldest.sv =====
// Bounded descriptor queue with drop-oldest. Each transaction on the input channel (send,
// receive, close or statistic read) yields exactly one result transaction. Throughput is one
// request per cycle unless the output stalls. Handles live in a 16-entry ring memory with
// registered read; the head slot is read on every request and the handle (dequeued or evicted)
// comes straight from the memory read port, while pointers, sticky close flag and saturating
// counters sit in flops. The input stalls only while a result is held by a stalled output.
// Configuration (capacity at 0x0, clamped to 1..16; policy at 0x4, 1 = drop oldest) is written
// over the APB port by the user only while the queue is idle; the block does not enforce it.
module bounded_descriptor_queue_drop_oldest (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bdq_pkg::ADDR_W-1:0]       paddr,
  input  logic [bdq_pkg::DATA_W-1:0]       pwdata,
  output logic [bdq_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       req_type_i,
  input  logic [bdq_pkg::HANDLE_BITS-1:0]  buffer_handle_i,
  input  logic [2:0]                       stat_select_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [bdq_pkg::HANDLE_BITS-1:0]  out_handle_o,
  output logic                             out_handle_valid_o,
  output logic                             dropped_valid_o,
  output logic [bdq_pkg::HANDLE_BITS-1:0]  dropped_handle_o,
  output logic [bdq_pkg::CNT_W-1:0]        depth_o,
  output logic [bdq_pkg::STAT_W-1:0]       stat_value_o
);

  bdq_pkg::cfg_t                   cfg;
  logic                            ram_we, ram_re;
  logic [bdq_pkg::PTR_W-1:0]       ram_waddr, ram_raddr;
  logic [bdq_pkg::HANDLE_BITS-1:0] ram_wdata, ram_rdata;

  bdq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bdq_ram #(
    .WIDTH (bdq_pkg::HANDLE_BITS),
    .DEPTH (bdq_pkg::QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bdq_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .buffer_handle_i    (buffer_handle_i),
    .stat_select_i      (stat_select_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .out_handle_o       (out_handle_o),
    .out_handle_valid_o (out_handle_valid_o),
    .dropped_valid_o    (dropped_valid_o),
    .dropped_handle_o   (dropped_handle_o),
    .depth_o            (depth_o),
    .stat_value_o       (stat_value_o),
    .ram_we_o           (ram_we),
    .ram_waddr_o        (ram_waddr),
    .ram_wdata_o        (ram_wdata),
    .ram_re_o           (ram_re),
    .ram_raddr_o        (ram_raddr),
    .ram_rdata_i        (ram_rdata)
  );

endmodule
